// ===== hdl/rcb_pkg.sv =====
package rcb_pkg;

  localparam int RAY_COUNT = 64;
  localparam int RAY_SLOTS = 64;
  localparam int RAY_AW    = $clog2(RAY_SLOTS);
  localparam int RAY_DEN   = 2 * RAY_COUNT;
  localparam int CNT_W     = 7;
  localparam int CFG_IW    = 1;
  localparam int CFG_DW    = 14;

  localparam longint COS_GA_Q30 = -64'sd791743804;
  localparam longint SIN_GA_Q30 = 64'sd725302181;

  localparam logic [CFG_IW-1:0] CFG_REACH       = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_MIN_SURFACE = 1'd1;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [29:0]        len2;
  } ray_t;

  typedef ray_t [RAY_SLOTS-1:0] ray_rom_t;

  typedef struct packed {
    logic               start;
    logic               active;
    logic               last_pass;
    logic signed [14:0] tx;
    logic signed [14:0] ty;
    logic signed [14:0] tz;
    logic [27:0]        d2;
    logic [19:0]        r2;
  } pass_cmd_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] hit_count;
  } pass_sts_t;

  function automatic longint isqrt(longint v);
    longint res;
    longint bitv;
    longint rem;
    res  = 0;
    bitv = 64'sd1 <<< 62;
    rem  = v;
    while (bitv > rem) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  function automatic longint rshift30(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic ray_rom_t build_rays();
    ray_rom_t rom;
    longint   c;
    longint   s;
    longint   a;
    longint   y;
    longint   rr;
    longint   x;
    longint   z;
    longint   nc;
    longint   ns;
    c   = 64'sd1 <<< 30;
    s   = 0;
    rom = '0;
    for (int i = 0; i < RAY_SLOTS; i++) begin
      if (i < RAY_COUNT) begin
        a = longint'(2 * (2 * i + 1 - RAY_COUNT) * 16384 + RAY_COUNT);
        if (a >= 0) y = a / RAY_DEN;
        else y = -((-a + RAY_DEN - 1) / RAY_DEN);
        rr = isqrt((64'sd1 <<< 28) - y * y);
        x  = rshift30(c * rr);
        z  = rshift30(s * rr);
        rom[i].x    = 16'(x);
        rom[i].y    = 16'(y);
        rom[i].z    = 16'(z);
        rom[i].len2 = 30'(x * x + y * y + z * z);
        nc = rshift30(c * COS_GA_Q30 - s * SIN_GA_Q30);
        ns = rshift30(s * COS_GA_Q30 + c * SIN_GA_Q30);
        c  = nc;
        s  = ns;
      end
    end
    return rom;
  endfunction

  localparam ray_rom_t RAY_ROM = build_rays();

endpackage

// ===== hdl/rcb_atom_if.sv =====
interface rcb_atom_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] atom_x;
  logic signed [23:0] atom_y;
  logic signed [23:0] atom_z;
  logic [9:0]         atom_radius;
  logic signed [23:0] query_x;
  logic signed [23:0] query_y;
  logic signed [23:0] query_z;
  logic               last_atom;

  modport source (
    output valid, atom_x, atom_y, atom_z, atom_radius, query_x, query_y, query_z, last_atom,
    input  ready
  );
  modport sink (
    input  valid, atom_x, atom_y, atom_z, atom_radius, query_x, query_y, query_z, last_atom,
    output ready
  );
endinterface

// ===== hdl/rcb_result_if.sv =====
interface rcb_result_if;
  logic        valid;
  logic        ready;
  logic [6:0]  hit_count;
  logic [16:0] score;
  logic        too_close;

  modport source (output valid, hit_count, score, too_close, input ready);
  modport sink (input valid, hit_count, score, too_close, output ready);
endinterface

// ===== hdl/rcb_ray_pass.sv =====
module rcb_ray_pass (
  input  logic              clk,
  input  logic              rst_n,
  input  rcb_pkg::pass_cmd_t cmd,
  output rcb_pkg::pass_sts_t sts
);

  logic                       busy_r;
  logic [rcb_pkg::RAY_AW-1:0] idx_r;
  logic                       v1_r, v2_r, v3_r, v4_r;
  logic                       fin1_r, fin2_r, fin3_r, fin4_r;
  logic [rcb_pkg::RAY_AW-1:0] idx1_r, idx2_r, idx3_r, idx4_r;
  rcb_pkg::ray_t              ray1_r;
  logic signed [30:0]         mx2_r, my2_r, mz2_r;
  logic [57:0]                lhs2_r, lhs3_r, lhs4_r;
  logic [49:0]                rl2_r, rl3_r, rl4_r;
  logic signed [32:0]         dot3_r;
  logic                       neg4_r;
  logic [59:0]                dsq4_r;
  logic                       rd_r;
  logic                       hit;
  logic                       newbit;
  logic                       done_r;
  logic [rcb_pkg::CNT_W-1:0]  cnt_r;
  logic                       hit_mem [rcb_pkg::RAY_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (busy_r) begin
        idx_r <= idx_r + 1'b1;
        if (idx_r == rcb_pkg::RAY_AW'(rcb_pkg::RAY_COUNT - 1)) busy_r <= 1'b0;
      end
      v1_r   <= busy_r;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      v4_r   <= v3_r;
      done_r <= v4_r && fin4_r;
    end
  end

  always_ff @(posedge clk) begin
    ray1_r <= rcb_pkg::RAY_ROM[idx_r];
    idx1_r <= idx_r;
    fin1_r <= (idx_r == rcb_pkg::RAY_AW'(rcb_pkg::RAY_COUNT - 1));
    mx2_r  <= 31'(ray1_r.x) * 31'(cmd.tx);
    my2_r  <= 31'(ray1_r.y) * 31'(cmd.ty);
    mz2_r  <= 31'(ray1_r.z) * 31'(cmd.tz);
    lhs2_r <= 58'(cmd.d2) * 58'(ray1_r.len2);
    rl2_r  <= 50'(cmd.r2) * 50'(ray1_r.len2);
    idx2_r <= idx1_r;
    fin2_r <= fin1_r;
    dot3_r <= 33'(mx2_r) + 33'(my2_r) + 33'(mz2_r);
    lhs3_r <= lhs2_r;
    rl3_r  <= rl2_r;
    idx3_r <= idx2_r;
    fin3_r <= fin2_r;
    neg4_r <= dot3_r[32];
    dsq4_r <= 60'(dot3_r[29:0]) * 60'(dot3_r[29:0]);
    lhs4_r <= lhs3_r;
    rl4_r  <= rl3_r;
    idx4_r <= idx3_r;
    fin4_r <= fin3_r;
  end

  assign hit    = cmd.active && !neg4_r && (61'(lhs4_r) <= 61'(rl4_r) + 61'(dsq4_r));
  assign newbit = rd_r | hit;

  always_ff @(posedge clk) begin
    rd_r <= hit_mem[idx3_r];
    if (v4_r) hit_mem[idx4_r] <= cmd.last_pass ? 1'b0 : newbit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.start) begin
      cnt_r <= '0;
    end else if (v4_r && cmd.last_pass) begin
      cnt_r <= cnt_r + rcb_pkg::CNT_W'(newbit);
    end
  end

  assign sts.done      = done_r;
  assign sts.hit_count = cnt_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !busy_r && !v1_r && !v2_r && !v3_r && !v4_r)
    else $error("pass started while another pass is in flight");

  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> !busy_r && !v1_r && !v2_r && !v3_r && !v4_r)
    else $error("pass reported done with rays still in flight");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |=> !sts.done)
    else $error("pass done held for more than one cycle");

endmodule

// ===== hdl/ray_cast_buriedness_score.sv =====
// Buriedness score of a query point among a stream of atoms.
// The in_atom channel takes one beat per atom: centre, radius, query point and
// a last_atom flag. The out_res channel gives one beat per query, after the
// beat flagged last_atom: hit count, Q1.16 score and the too_close flag.
// The cfg port writes the probe reach (index 0) and min_surface_distance
// (index 1) into registers; it is to be written only while the block is idle.
// For each atom the block squares the distances and makes the decision, then
// streams one ray direction per cycle through a pipeline that reads, updates
// and writes back the per-ray hit memory; the pipeline then drains and the
// block returns to idle. The last atom of a query then passes through the
// output state, which loads its result. Each atom makes one read-modify-write
// pass over the hit memory.
// One atom is in work at a time; in_atom is ready only between atoms.
// After reset the block runs one pass over the hit memory to clear it, and
// in_atom first goes ready when that pass is done. A result waits in
// the output register while the receiver stalls; the block takes the next
// query's atoms meanwhile, and holds the next result back until the previous
// one has been taken.
module ray_cast_buriedness_score (
  input  logic                         clk,
  input  logic                         rst_n,
  rcb_atom_if.sink                     in_atom,
  rcb_result_if.source                 out_res,
  input  logic                         cfg_we,
  input  logic [rcb_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [rcb_pkg::CFG_DW-1:0]   cfg_data
);

  typedef enum logic [2:0] {
    ST_INIT, ST_INIT_WAIT, ST_IDLE, ST_SQ, ST_DEC, ST_PASS, ST_OUT
  } state_t;

  state_t             state_r;
  logic [13:0]        probe_r;
  logic [11:0]        msd_r;
  logic signed [24:0] tx_r, ty_r, tz_r;
  logic [9:0]         rad_r;
  logic               last_r;
  logic               active_r;
  logic               blocked_r;
  logic               start_r;
  logic [49:0]        sqx_r, sqy_r, sqz_r;
  logic [25:0]        lim2_r;
  logic [27:0]        probe2_r;
  logic [19:0]        r2_r;
  logic [27:0]        d2_r;
  logic [51:0]        d2_full;
  logic [12:0]        lim;
  logic               out_valid_r;
  logic [6:0]         hc_r;
  logic [16:0]        score_r;
  logic               tc_r;
  rcb_pkg::pass_cmd_t cmd;
  rcb_pkg::pass_sts_t sts;

  assign d2_full = 52'(sqx_r) + 52'(sqy_r) + 52'(sqz_r);
  assign lim     = 13'(rad_r) + 13'(msd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= 14'd2048;
      msd_r   <= 12'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcb_pkg::CFG_REACH:       probe_r <= cfg_data;
        rcb_pkg::CFG_MIN_SURFACE: msd_r   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      start_r     <= 1'b0;
      last_r      <= 1'b1;
      active_r    <= 1'b0;
      blocked_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (out_valid_r && out_res.ready && state_r != ST_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_INIT: begin
          start_r <= 1'b1;
          state_r <= ST_INIT_WAIT;
        end
        ST_INIT_WAIT: begin
          if (sts.done) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_atom.valid) begin
            tx_r    <= 25'(in_atom.atom_x) - 25'(in_atom.query_x);
            ty_r    <= 25'(in_atom.atom_y) - 25'(in_atom.query_y);
            tz_r    <= 25'(in_atom.atom_z) - 25'(in_atom.query_z);
            rad_r   <= in_atom.atom_radius;
            last_r  <= in_atom.last_atom;
            state_r <= ST_SQ;
          end
        end
        ST_SQ: begin
          sqx_r    <= 50'(tx_r) * 50'(tx_r);
          sqy_r    <= 50'(ty_r) * 50'(ty_r);
          sqz_r    <= 50'(tz_r) * 50'(tz_r);
          lim2_r   <= 26'(lim) * 26'(lim);
          probe2_r <= 28'(probe_r) * 28'(probe_r);
          r2_r     <= 20'(rad_r) * 20'(rad_r);
          state_r  <= ST_DEC;
        end
        ST_DEC: begin
          active_r <= 1'b0;
          if (!blocked_r) begin
            if (d2_full < 52'(lim2_r)) begin
              blocked_r <= 1'b1;
            end else if (d2_full != '0 && d2_full <= 52'(probe2_r)) begin
              active_r <= 1'b1;
            end
          end
          d2_r    <= d2_full[27:0];
          start_r <= 1'b1;
          state_r <= ST_PASS;
        end
        ST_PASS: begin
          if (sts.done) state_r <= last_r ? ST_OUT : ST_IDLE;
        end
        ST_OUT: begin
          if (!out_valid_r || out_res.ready) begin
            out_valid_r <= 1'b1;
            tc_r        <= blocked_r;
            hc_r        <= blocked_r ? 7'd0 : sts.hit_count;
            score_r     <= blocked_r ? 17'd0
                         : 17'(({16'd0, sts.hit_count} << 16) / rcb_pkg::RAY_COUNT);
            blocked_r   <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign cmd.start     = start_r;
  assign cmd.active    = active_r;
  assign cmd.last_pass = last_r;
  assign cmd.tx        = tx_r[14:0];
  assign cmd.ty        = ty_r[14:0];
  assign cmd.tz        = tz_r[14:0];
  assign cmd.d2        = d2_r;
  assign cmd.r2        = r2_r;

  rcb_ray_pass u_pass (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .sts   (sts)
  );

  assign in_atom.ready     = (state_r == ST_IDLE);
  assign out_res.valid     = out_valid_r;
  assign out_res.hit_count = hc_r;
  assign out_res.score     = score_r;
  assign out_res.too_close = tc_r;

  a_blocked_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.too_close |-> out_res.hit_count == 7'd0 && out_res.score == 17'd0)
    else $error("blocked query reported hits");

  a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result loaded outside the output state");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.ready |=> out_res.valid && $stable(out_res.hit_count)
      && $stable(out_res.score) && $stable(out_res.too_close))
    else $error("result beat changed while stalled");

endmodule
